>>> hdl/smps_pkg.sv
// Shared types and constants of the stepper phase move sequencer.
// Used by smps_phase, smps_core, the top level and its checker.
// No dependencies.
`timescale 1ns / 1ps

package smps_pkg;

  // Widths fixed by the item and register fields
  localparam int LEVEL_BITS     = 16;
  localparam int AMP_BITS       = 16;
  localparam int PHASE_BITS     = 3;
  localparam int COUNT_BITS     = 32;
  localparam int DELAY_BITS     = 16;
  localparam int OUT_POS_BITS   = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int IN_DATA_BITS   = 80;
  localparam int OUT_DATA_BITS  = 120;

  // Amplitude ceiling; register writes above it saturate
  localparam logic [AMP_BITS-1:0] AMP_LIMIT = 16'd32768;

  // Command codes carried in the input tuser bit
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_ZERO   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_HALF   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_FULL   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMP_MOVING   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMP_HOLDING  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_MODE    = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_IDLE = 3'd6;

  // Register reset values
  localparam logic [LEVEL_BITS-1:0] LEVEL_ZERO_RST  = 16'd0;
  localparam logic [LEVEL_BITS-1:0] LEVEL_HALF_RST  = 16'd16384;
  localparam logic [LEVEL_BITS-1:0] LEVEL_FULL_RST  = 16'd32767;
  localparam logic [AMP_BITS-1:0]   AMP_MOVING_RST  = 16'd32768;
  localparam logic [AMP_BITS-1:0]   AMP_HOLDING_RST = 16'd8192;

  // Four coil levels, entry 0 is coil a
  typedef logic [3:0][LEVEL_BITS-1:0] coil_set_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [LEVEL_BITS-1:0] level_zero;
    logic [LEVEL_BITS-1:0] level_half;
    logic [LEVEL_BITS-1:0] level_full;
    logic [AMP_BITS-1:0]   amp_moving;
    logic [AMP_BITS-1:0]   amp_holding;
    logic                  half_mode;
    logic                  release_idle;
  } cfg_t;

  // One result item
  typedef struct packed {
    coil_set_t                 coils;
    logic [AMP_BITS-1:0]       amplitude;
    logic [OUT_POS_BITS-1:0]   position;
    logic                      moving;
    logic                      done_res;
  } res_t;

endpackage

>>> hdl/stepper_phase_move_sequencer.sv
// Stepper phase move sequencer: top level with configuration registers,
// input register and result register. Depends on smps_pkg and smps_core.
`timescale 1ns / 1ps

// One item per clock is accepted while the output keeps up, and each gives
// exactly one result. An item is held in the input register; when it moves
// on, the move state is updated and the result is loaded into the output
// register, from which it can be taken when the output side is free.
// Throughput is set by the output register: while it is full and not taken,
// the input register holds one more item and then input transfers stop. A
// start item (tuser 0) loads position, step count and delay; tick items
// (tuser 1) pace the move, one step every delay_quanta+1 ticks. tlast marks
// the result that ends a move.
// Configuration may be written only while no item is in flight.

module stepper_phase_move_sequencer #(
  parameter int POSITION_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // start_position[31:0], step_count[63:32], delay_quanta[79:64]
  input  logic [smps_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // cmd[0]
  input  logic                                 s_axis_tuser,
  // Output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // coil_a[15:0], coil_b[31:16], coil_c[47:32], coil_d[63:48],
  // amplitude[79:64], position[111:80], moving[112], zero fill[119:113]
  output logic [smps_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  // done_res
  output logic                                 m_axis_tlast,
  // Configuration write port
  input  logic                                 cfg_we,
  input  logic [smps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [smps_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import smps_pkg::*;

  cfg_t                    cfg;
  logic [AMP_BITS-1:0]     amp_sat;

  logic                    in_valid;
  logic                    in_cmd;
  logic [IN_DATA_BITS-1:0] in_data;
  logic                    advance;

  res_t                    step_res;
  res_t                    out_res;
  logic                    out_valid;

  // Amplitude writes saturate at the limit
  assign amp_sat = (cfg_data > AMP_LIMIT) ? AMP_LIMIT : cfg_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_zero   <= LEVEL_ZERO_RST;
      cfg.level_half   <= LEVEL_HALF_RST;
      cfg.level_full   <= LEVEL_FULL_RST;
      cfg.amp_moving   <= AMP_MOVING_RST;
      cfg.amp_holding  <= AMP_HOLDING_RST;
      cfg.half_mode    <= 1'b0;
      cfg.release_idle <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEVEL_ZERO:   cfg.level_zero   <= cfg_data;
        REG_LEVEL_HALF:   cfg.level_half   <= cfg_data;
        REG_LEVEL_FULL:   cfg.level_full   <= cfg_data;
        REG_AMP_MOVING:   cfg.amp_moving   <= amp_sat;
        REG_AMP_HOLDING:  cfg.amp_holding  <= amp_sat;
        REG_HALF_MODE:    cfg.half_mode    <= cfg_data[0];
        REG_RELEASE_IDLE: cfg.release_idle <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The held item moves on when the result register is free or being emptied
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd  <= s_axis_tuser;
      in_data <= s_axis_tdata;
    end
  end

  smps_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .cmd            (in_cmd),
    .start_position (in_data[31:0]),
    .step_count     (in_data[63:32]),
    .delay_quanta   (in_data[79:64]),
    .cfg            (cfg),
    .res            (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  // Output packing
  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_res.done_res;
  assign m_axis_tdata  = {7'd0, out_res.moving, out_res.position, out_res.amplitude,
                          out_res.coils};

endmodule

>>> hdl/smps_phase.sv
// Phase decoder: coil drive for the current phase and the phase after one step.
// Depends on smps_pkg.
`timescale 1ns / 1ps

module smps_phase (
  input  logic [smps_pkg::PHASE_BITS-1:0] phase,
  input  logic                            ccw,
  input  smps_pkg::cfg_t                  cfg,
  output smps_pkg::coil_set_t             coils,
  output logic [smps_pkg::PHASE_BITS-1:0] phase_next
);
  import smps_pkg::*;

  logic [LEVEL_BITS-1:0] z;
  logic [LEVEL_BITS-1:0] h;
  logic [LEVEL_BITS-1:0] f;

  assign z = cfg.level_zero;
  assign h = cfg.level_half;
  assign f = cfg.level_full;

  // Drive table and phase move; concatenations list coil d first
  always_comb begin
    coils      = {z, z, z, z};
    phase_next = phase;
    if (cfg.half_mode) begin
      unique case (phase)
        3'd7: coils = {h, z, h, z};
        3'd6: coils = {f, z, z, z};
        3'd5: coils = {h, z, z, h};
        3'd4: coils = {z, z, z, f};
        3'd3: coils = {z, h, z, h};
        3'd2: coils = {z, f, z, z};
        3'd1: coils = {z, h, h, z};
        3'd0: coils = {z, z, f, z};
        default: coils = {z, z, f, z};
      endcase
      // Clockwise lowers the phase, counter-clockwise raises it
      phase_next = ccw ? phase + 3'd1 : phase - 3'd1;
    end else if (phase[0]) begin
      // An odd phase has no full-step entry: drop the drive and restart at 0
      coils      = {z, z, z, z};
      phase_next = '0;
    end else begin
      unique case (phase[2:1])
        2'd3: coils = {f, z, z, f};
        2'd2: coils = {z, f, z, f};
        2'd1: coils = {z, f, f, z};
        2'd0: coils = {f, z, f, z};
        default: coils = {f, z, f, z};
      endcase
      phase_next = ccw ? phase + 3'd2 : phase - 3'd2;
    end
  end

endmodule

>>> hdl/smps_core.sv
// Move state and per-item update: start loading, tick pacing, stepping and finishing.
// Depends on smps_pkg and smps_phase.
`timescale 1ns / 1ps

module smps_core #(
  parameter int POSITION_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              cmd,
  input  logic signed [31:0]                start_position,
  input  logic signed [31:0]                step_count,
  input  logic [smps_pkg::DELAY_BITS-1:0]   delay_quanta,
  input  smps_pkg::cfg_t                    cfg,
  output smps_pkg::res_t                    res
);
  import smps_pkg::*;

  // Move state
  logic [PHASE_BITS-1:0]    phase_index;
  logic                     counter_clockwise;
  logic [COUNT_BITS-1:0]    steps_left;
  logic [DELAY_BITS-1:0]    wait_count;
  logic [DELAY_BITS-1:0]    delay_reload;
  logic [POSITION_BITS-1:0] position_count;
  coil_set_t                coil_levels;
  logic [AMP_BITS-1:0]      amplitude_now;
  logic                     busy;

  logic [PHASE_BITS-1:0]    phase_index_next;
  logic                     counter_clockwise_next;
  logic [COUNT_BITS-1:0]    steps_left_next;
  logic [DELAY_BITS-1:0]    wait_count_next;
  logic [DELAY_BITS-1:0]    delay_reload_next;
  logic [POSITION_BITS-1:0] position_count_next;
  coil_set_t                coil_levels_next;
  logic [AMP_BITS-1:0]      amplitude_now_next;
  logic                     busy_next;
  logic                     done;

  coil_set_t                step_coils;
  logic [PHASE_BITS-1:0]    step_phase;
  logic [63:0]              start_wide;
  logic [COUNT_BITS-1:0]    count_u;
  logic [COUNT_BITS-1:0]    count_mag;
  logic signed [POSITION_BITS-1:0] pos_signed;
  logic [63:0]              pos_wide;

  smps_phase u_phase (
    .phase      (phase_index),
    .ccw        (counter_clockwise),
    .cfg        (cfg),
    .coils      (step_coils),
    .phase_next (step_phase)
  );

  // Start fields: sign-extended position and step magnitude
  assign start_wide = 64'(start_position);
  assign count_u    = step_count;
  assign count_mag  = step_count[31] ? (32'd0 - count_u) : count_u;

  // Next state for one accepted item
  always_comb begin
    phase_index_next       = phase_index;
    counter_clockwise_next = counter_clockwise;
    steps_left_next        = steps_left;
    wait_count_next        = wait_count;
    delay_reload_next      = delay_reload;
    position_count_next    = position_count;
    coil_levels_next       = coil_levels;
    amplitude_now_next     = amplitude_now;
    busy_next              = busy;
    done                   = 1'b0;
    if (en) begin
      priority if (cmd == CMD_START) begin
        position_count_next    = start_wide[POSITION_BITS-1:0];
        counter_clockwise_next = step_count[31];
        steps_left_next        = count_mag;
        delay_reload_next      = delay_quanta;
        wait_count_next        = delay_quanta;
        amplitude_now_next     = cfg.amp_moving;
        busy_next              = 1'b1;
        done                   = (count_mag == '0);
      end else if (busy) begin
        if (wait_count != '0) begin
          wait_count_next = wait_count - 16'd1;
        end else begin
          steps_left_next  = steps_left - 32'd1;
          coil_levels_next = step_coils;
          phase_index_next = step_phase;
          position_count_next = counter_clockwise
                              ? position_count - POSITION_BITS'(1)
                              : position_count + POSITION_BITS'(1);
          wait_count_next  = delay_reload;
          done             = (steps_left == 32'd1);
        end
      end else begin
        // A tick while idle leaves the state as it is
      end
      // Move end: holding amplitude, optional coil release
      if (done) begin
        amplitude_now_next = cfg.amp_holding;
        if (cfg.release_idle) begin
          coil_levels_next = {4{cfg.level_zero}};
        end
        busy_next = 1'b0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index       <= '0;
      counter_clockwise <= 1'b0;
      steps_left        <= '0;
      wait_count        <= '0;
      delay_reload      <= '0;
      position_count    <= '0;
      coil_levels       <= '0;
      amplitude_now     <= '0;
      busy              <= 1'b0;
    end else begin
      phase_index       <= phase_index_next;
      counter_clockwise <= counter_clockwise_next;
      steps_left        <= steps_left_next;
      wait_count        <= wait_count_next;
      delay_reload      <= delay_reload_next;
      position_count    <= position_count_next;
      coil_levels       <= coil_levels_next;
      amplitude_now     <= amplitude_now_next;
      busy              <= busy_next;
    end
  end

  // Result reflects the state after this item
  assign pos_signed = position_count_next;
  assign pos_wide   = 64'(pos_signed);

  always_comb begin
    res.coils     = coil_levels_next;
    res.amplitude = amplitude_now_next;
    res.position  = pos_wide[OUT_POS_BITS-1:0];
    res.moving    = busy_next;
    res.done_res  = done;
  end

endmodule

>>> hdl/smps_checker.sv
// Port-level checker for the stepper phase move sequencer, bound to the top level.
// Depends on smps_pkg and stepper_phase_move_sequencer.
`timescale 1ns / 1ps

module smps_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [smps_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  input logic                                m_axis_tlast
);
  import smps_pkg::*;

  // A result refused by the sink stays offered unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // The result that ends a move never reports a move still running
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[112])
    else $error("move end reported while still moving");

  // Amplitude never exceeds its ceiling
  a_amp_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[79:64] <= AMP_LIMIT)
    else $error("amplitude above limit");

  // No result is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result offered after reset");

endmodule

bind stepper_phase_move_sequencer smps_checker u_smps_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
